### rtl/kqt_pkg.sv
`default_nettype none

package kqt_pkg;

    localparam int KeyWidth    = 64;
    localparam int AmountWidth = 16;
    localparam int QtyWidth    = 31;
    localparam int CountWidth  = 5;
    localparam int OpWidth     = 3;

    localparam logic [QtyWidth-1:0] QtyMax = {QtyWidth{1'b1}};

    // operation codes; codes above OP_CLEAR are refused
    localparam logic [OpWidth-1:0] OP_ADD    = 3'd0;
    localparam logic [OpWidth-1:0] OP_REMOVE = 3'd1;
    localparam logic [OpWidth-1:0] OP_QUERY  = 3'd2;
    localparam logic [OpWidth-1:0] OP_COUNT  = 3'd3;
    localparam logic [OpWidth-1:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [OpWidth-1:0]     operation;
        logic [KeyWidth-1:0]    key;
        logic [AmountWidth-1:0] amount;
    } kqt_req_t;

    typedef struct packed {
        logic                  accepted;
        logic [QtyWidth-1:0]   quantity;
        logic [CountWidth-1:0] entry_count;
    } kqt_rsp_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                look;       // capture hit and free-slot claim
        logic                clear_all;  // drop every entry
        logic                wr_hit;     // write amount into the hit entry
        logic                free_hit;   // release the hit entry
        logic                wr_claim;   // fill the claimed free entry
        logic [QtyWidth-1:0] amount;
    } kqt_cmd_t;

endpackage

`default_nettype wire

### rtl/kqt_cell.sv
`default_nettype none

module kqt_cell
    import kqt_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kqt_cmd_t            cmd,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic                free_seen_in,
    output logic                     free_seen_out,
    output logic                     match,
    output logic [QtyWidth-1:0]      sel_amount
);

    logic                valid_reg;
    logic                valid_next;
    logic                hit_reg;
    logic                claim_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [QtyWidth-1:0] amount_reg;

    assign match         = valid_reg && (key_reg == key);
    assign sel_amount    = match ? amount_reg : '0;
    // pass the "free slot already seen" mark to the next cell
    assign free_seen_out = free_seen_in | ~valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_all)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.free_hit && hit_reg)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.wr_claim && claim_reg)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            claim_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.look)
            begin
                hit_reg   <= match;
                claim_reg <= ~valid_reg & ~free_seen_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_hit && hit_reg)
        begin
            amount_reg <= cmd.amount;
        end
        else if (cmd.wr_claim && claim_reg)
        begin
            key_reg    <= key;
            amount_reg <= cmd.amount;
        end
    end

endmodule

`default_nettype wire

### rtl/keyed_quantity_table.sv
// Keyed counter table: ENTRIES cells, each holding one key and its count.
// Every request transaction carries an operation (add, remove, query, count,
// clear), a key and an amount, and yields exactly one response transaction
// with an accepted flag, the queried quantity and the number of entries in
// use after the operation. Only the low KEY_BITS bits of a key are stored and
// compared. Counts saturate at 2^31-1; remove frees an entry once its count
// reaches zero; add of a new key fills the lowest-numbered free cell.
// A transaction runs through a look step, in which all cells compare the key
// in parallel and the free-slot mark ripples down the cell row, then an apply
// step, in which the chosen cell is read-modify-written and the response is
// loaded into the output register. The apply step waits while a previous
// response has not been taken, so a stalled response delays the transaction.
// No clearing pass follows reset: the table is empty immediately.
`default_nettype none

module keyed_quantity_table
    import kqt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire kqt_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output kqt_rsp_t      rsp
);

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // captured request
    logic [OpWidth-1:0]     op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [AmountWidth-1:0] amt_reg;

    // results of the compare cycle
    logic                any_hit_reg;
    logic                any_free_reg;
    logic [QtyWidth-1:0] cur_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    kqt_rsp_t rsp_reg;
    kqt_rsp_t rsp_next;

    kqt_cmd_t cmd;
    logic     apply_go;
    logic     req_fire;

    // cell row wiring
    logic [ENTRIES:0]    free_chain;
    logic [ENTRIES-1:0]  cell_match;
    logic [QtyWidth-1:0] cell_amount [ENTRIES];
    logic [QtyWidth-1:0] or_amount;

    logic [QtyWidth:0]   add_sum;
    logic [QtyWidth-1:0] add_sat;
    logic [QtyWidth-1:0] amt_ext;
    logic [CW+CountWidth-1:0] count_ext;

    assign apply_go  = (state_reg == S_APPLY) && (!rsp_valid_reg || rsp_ready);
    // take the next request in the same cycle the current one retires
    assign req_ready = (state_reg == S_IDLE) || apply_go;
    assign req_fire  = req_valid && req_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kqt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .key           (key_reg),
            .free_seen_in  (free_chain[i]),
            .free_seen_out (free_chain[i+1]),
            .match         (cell_match[i]),
            .sel_amount    (cell_amount[i])
        );
    end

    // keys are unique among valid cells, so at most one term is nonzero
    always_comb
    begin
        or_amount = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            or_amount = or_amount | cell_amount[i];
        end
    end

    assign amt_ext = QtyWidth'(amt_reg);
    assign add_sum = {1'b0, cur_reg} + {1'b0, amt_ext};
    assign add_sat = add_sum[QtyWidth] ? QtyMax : add_sum[QtyWidth-1:0];

    assign count_ext = {{CountWidth{1'b0}}, count_next};

    // apply: decide the table update and build the response
    always_comb
    begin
        cmd          = '0;
        cmd.look     = (state_reg == S_LOOK);
        count_next   = count_reg;
        rsp_next     = rsp_reg;
        if (apply_go)
        begin
            rsp_next = '0;
            unique case (op_reg)
                OP_ADD:
                begin
                    if (amt_reg != '0)
                    begin
                        if (any_hit_reg)
                        begin
                            cmd.wr_hit        = 1'b1;
                            cmd.amount        = add_sat;
                            rsp_next.accepted = 1'b1;
                        end
                        else if (any_free_reg)
                        begin
                            cmd.wr_claim      = 1'b1;
                            cmd.amount        = amt_ext;
                            count_next        = count_reg + CW'(1);
                            rsp_next.accepted = 1'b1;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if ((amt_reg != '0) && any_hit_reg)
                    begin
                        if (cur_reg <= amt_ext)
                        begin
                            cmd.free_hit = 1'b1;
                            count_next   = count_reg - CW'(1);
                        end
                        else
                        begin
                            cmd.wr_hit = 1'b1;
                            cmd.amount = cur_reg - amt_ext;
                        end
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    // cur_reg is zero when the key is absent
                    rsp_next.quantity = cur_reg;
                    rsp_next.accepted = 1'b1;
                end
                OP_COUNT:
                begin
                    rsp_next.accepted = 1'b1;
                end
                OP_CLEAR:
                begin
                    cmd.clear_all     = 1'b1;
                    count_next        = '0;
                    rsp_next.accepted = 1'b1;
                end
                default:
                begin
                    rsp_next.accepted = 1'b0;
                end
            endcase
            rsp_next.entry_count = count_ext[CountWidth-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = req_fire ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (apply_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload: request capture, compare results, response
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.operation;
            key_reg <= req.key[KEY_BITS-1:0];
            amt_reg <= req.amount;
        end
        if (state_reg == S_LOOK)
        begin
            any_hit_reg  <= |cell_match;
            any_free_reg <= free_chain[ENTRIES];
            cur_reg      <= or_amount;
        end
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

### rtl/kqt_checker.sv
`default_nettype none

module kqt_checker
    import kqt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire kqt_rsp_t rsp
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a request needs a compare cycle before the next one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken during compare cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (ENTRIES > 31) || (int'(rsp.entry_count) <= ENTRIES))
        else $error("entry count exceeds table size");

    a_qty_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.quantity != '0) |-> rsp.accepted)
        else $error("nonzero quantity on refused response");

    // a fresh response traces back to the request that made it
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
        else $error("response without a matching request");

endmodule

bind keyed_quantity_table kqt_checker #(
    .ENTRIES (ENTRIES)
) u_kqt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

### sim/tb.sv
module tb;
    import kqt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_LEN     = 64;

    // Opcodes past OP_CLEAR are refused by the block.
    localparam logic [OpWidth-1:0] OP_BAD_LO = OP_CLEAR + 3'd1;
    localparam logic [OpWidth-1:0] OP_BAD_HI = OP_CLEAR + 3'd3;

    localparam logic [KeyWidth-1:0] KEY_MASK  = {KeyWidth{1'b1}} >> (KeyWidth - KEY_LEN);
    localparam logic [KeyWidth-1:0] KEY_ZERO  = '0;
    localparam logic [KeyWidth-1:0] KEY_ONES  = '1;
    localparam logic [KeyWidth-1:0] KEY_TOP   = 64'h8000_0000_0000_0000;
    localparam logic [KeyWidth-1:0] KEY_ALT   = 64'h5555_5555_5555_5555;

    localparam logic [AmountWidth-1:0] AMT_MAX = '1;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL    = 200;
    localparam int KEY_POOL     = 24;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        kqt_req_t item;
        logic     typed;
        kqt_rsp_t want;
    } script_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    kqt_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    kqt_rsp_t rsp;

    // Shadow copy of the table as the block should hold it.
    logic                slot_used [TABLE_DEPTH];
    logic [KeyWidth-1:0] slot_key  [TABLE_DEPTH];
    logic [QtyWidth-1:0] slot_qty  [TABLE_DEPTH];

    kqt_rsp_t    tally_due[$];
    script_row_t directed_rows[$];
    logic [KeyWidth-1:0] key_pool [KEY_POOL];

    int mismatches = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    keyed_quantity_table #(
        .ENTRIES  (TABLE_DEPTH),
        .KEY_BITS (KEY_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #20_000_000;
        $display("[keyed_quantity_table] ERROR");
        $finish;
    end

    // Apply one request transaction to the shadow table and return the
    // response the block owes for it.
    function automatic kqt_rsp_t tally_step(input kqt_req_t r);
        kqt_rsp_t            res;
        logic [KeyWidth-1:0] k;
        logic [QtyWidth:0]   sum;
        int                  hit;
        int                  spot;
        int                  used;
        res  = '0;
        k    = r.key & KEY_MASK;
        hit  = -1;
        spot = -1;
        used = 0;
        // Walk downward so the lowest-numbered match and free slot win.
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!slot_used[i])
                spot = i;
            else if (slot_key[i] == k)
                hit = i;
        end
        case (r.operation)
            OP_ADD:
            begin
                if (r.amount != '0 && hit >= 0)
                begin
                    // Saturate at the ceiling instead of wrapping.
                    sum = {1'b0, slot_qty[hit]} + (QtyWidth + 1)'(r.amount);
                    slot_qty[hit] = sum[QtyWidth] ? QtyMax : sum[QtyWidth-1:0];
                    res.accepted = 1'b1;
                end
                else if (r.amount != '0 && spot >= 0)
                begin
                    slot_used[spot] = 1'b1;
                    slot_key[spot]  = k;
                    slot_qty[spot]  = QtyWidth'(r.amount);
                    res.accepted    = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (r.amount != '0 && hit >= 0)
                begin
                    // Drop the entry once the count would reach zero.
                    if (slot_qty[hit] <= QtyWidth'(r.amount))
                    begin
                        slot_used[hit] = 1'b0;
                        slot_qty[hit]  = '0;
                    end
                    else
                        slot_qty[hit] = slot_qty[hit] - QtyWidth'(r.amount);
                    res.accepted = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (hit >= 0)
                    res.quantity = slot_qty[hit];
                res.accepted = 1'b1;
            end
            OP_COUNT:
                res.accepted = 1'b1;
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    slot_used[i] = 1'b0;
                res.accepted = 1'b1;
            end
            default:
                res.accepted = 1'b0;
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++)
            used += int'(slot_used[i]);
        res.entry_count = CountWidth'(used);
        return res;
    endfunction

    // Queue a directed row; typed rows carry the response written out here.
    task automatic plan(input logic [OpWidth-1:0] op, input logic [KeyWidth-1:0] k,
                        input logic [AmountWidth-1:0] amt, input logic typed,
                        input logic acc, input logic [QtyWidth-1:0] qty,
                        input logic [CountWidth-1:0] cnt);
        script_row_t row;
        row.item.operation = op;
        row.item.key       = k;
        row.item.amount    = amt;
        row.typed          = typed;
        row.want.accepted    = acc;
        row.want.quantity    = qty;
        row.want.entry_count = cnt;
        directed_rows.push_back(row);
    endtask

    // Present one request transaction, hold it until taken, then record the
    // expected response. Valid is only lowered when an idle burst follows, so
    // back-to-back transactions keep valid high across the edge.
    task automatic offer(input kqt_req_t item, input logic typed, input kqt_rsp_t want);
        kqt_rsp_t model;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        model = tally_step(item);
        tally_due.push_back(typed ? want : model);
    endtask

    // Response side: stall in bursts of random length while stall_pct is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= rst_n;
    end

    // Compare every taken response transaction with the oldest expectation.
    always @(posedge clk)
    begin
        kqt_rsp_t due;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (tally_due.size() == 0)
            begin
                $error("response with nothing outstanding: accepted %0d quantity %0d count %0d",
                       rsp.accepted, rsp.quantity, rsp.entry_count);
                mismatches++;
            end
            else
            begin
                due = tally_due.pop_front();
                if (rsp.accepted !== due.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", due.accepted, rsp.accepted);
                    mismatches++;
                end
                if (rsp.quantity !== due.quantity)
                begin
                    $error("quantity: expected %0d, got %0d", due.quantity, rsp.quantity);
                    mismatches++;
                end
                if (rsp.entry_count !== due.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           due.entry_count, rsp.entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        kqt_req_t item;
        int       roll;
        int       fill_mode;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_qty[i]  = '0;
        end
        // A small key pool makes hits, refills and a full table common.
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed rows: empty table, refusals, extremes, freeing, clear.
        plan(OP_COUNT,  KEY_ZERO, '0,      1'b1, 1'b1, '0,     5'd0);
        plan(OP_QUERY,  KEY_ZERO, AMT_MAX, 1'b1, 1'b1, '0,     5'd0);
        plan(OP_ADD,    KEY_ZERO, '0,      1'b1, 1'b0, '0,     5'd0);
        plan(OP_REMOVE, KEY_ZERO, '0,      1'b1, 1'b0, '0,     5'd0);
        plan(OP_REMOVE, KEY_ONES, 16'd1,   1'b1, 1'b0, '0,     5'd0);
        plan(OP_BAD_LO, KEY_ZERO, 16'd1,   1'b1, 1'b0, '0,     5'd0);
        plan(OP_BAD_LO + 3'd1, KEY_ONES, AMT_MAX, 1'b1, 1'b0, '0, 5'd0);
        plan(OP_BAD_HI, KEY_TOP,  AMT_MAX, 1'b1, 1'b0, '0,     5'd0);
        plan(OP_ADD,    KEY_ZERO, AMT_MAX, 1'b1, 1'b1, '0,     5'd1);
        plan(OP_ADD,    KEY_ONES, 16'd1,   1'b1, 1'b1, '0,     5'd2);
        plan(OP_QUERY,  KEY_ZERO, '0,      1'b1, 1'b1, 31'hffff, 5'd2);
        plan(OP_QUERY,  KEY_ONES, '0,      1'b1, 1'b1, 31'd1,  5'd2);
        plan(OP_ADD,    KEY_TOP,  16'h8000, 1'b0, 1'b0, '0,    '0);
        // remove more than held, then exactly what is held
        plan(OP_REMOVE, KEY_ONES, AMT_MAX, 1'b1, 1'b1, '0,     5'd2);
        plan(OP_REMOVE, KEY_ZERO, AMT_MAX, 1'b1, 1'b1, '0,     5'd1);
        plan(OP_QUERY,  KEY_ZERO, '0,      1'b1, 1'b1, '0,     5'd1);
        plan(OP_ADD,    KEY_ALT,  16'haaaa, 1'b0, 1'b0, '0,    '0);
        plan(OP_REMOVE, KEY_ALT,  16'h5555, 1'b0, 1'b0, '0,    '0);
        plan(OP_QUERY,  KEY_ALT,  '0,      1'b0, 1'b0, '0,     '0);
        plan(OP_COUNT,  KEY_ONES, AMT_MAX, 1'b0, 1'b0, '0,     '0);
        plan(OP_CLEAR,  KEY_ZERO, '0,      1'b1, 1'b1, '0,     5'd0);
        plan(OP_QUERY,  KEY_ALT,  '0,      1'b1, 1'b1, '0,     5'd0);
        // stale keys left behind by clear must not match
        plan(OP_ADD,    KEY_TOP,  16'd1,   1'b1, 1'b1, '0,     5'd1);
        plan(OP_QUERY,  KEY_TOP,  '0,      1'b1, 1'b1, 31'd1,  5'd1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Random traffic, paced in blocks of 100 transactions; the tail runs
        // with no idling on either side.
        fill_mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                roll      = $urandom_range(0, 2);
                gap_pct   = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
                roll      = $urandom_range(0, 2);
                stall_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
                fill_mode = ($urandom_range(0, 2) == 0);
            end
            if (n >= RANDOM_ITEMS - CALM_TAIL)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            roll = $urandom_range(0, 99);
            if (fill_mode)
                item.operation = (roll < 70) ? OP_ADD : (roll < 75) ? OP_REMOVE :
                                 (roll < 95) ? OP_QUERY : OP_COUNT;
            else if (roll < 42)
                item.operation = OP_ADD;
            else if (roll < 62)
                item.operation = OP_REMOVE;
            else if (roll < 84)
                item.operation = OP_QUERY;
            else if (roll < 92)
                item.operation = OP_COUNT;
            else if (roll < 94)
                item.operation = OP_CLEAR;
            else if (roll < 97)
                item.operation = OP_BAD_LO + OpWidth'($urandom_range(0, 2));
            else
                item.operation = OP_ADD;

            // Mostly pooled keys; the rest sweep every key bit.
            if ($urandom_range(0, 99) < 85)
                item.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else
                item.key = {$urandom, $urandom};

            roll = $urandom_range(0, 99);
            if (roll < 5)
                item.amount = '0;
            else if (roll < 35)
                item.amount = AmountWidth'($urandom_range(1, 16));
            else if (roll < 45)
                item.amount = AMT_MAX;
            else
                item.amount = AmountWidth'($urandom_range(1, 65535));

            offer(item, 1'b0, '0);
        end

        // Drain: wait out every outstanding response, then watch for strays.
        req_valid <= 1'b0;
        while (tally_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[keyed_quantity_table] OK");
        else
            $display("[keyed_quantity_table] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/kqt_pkg.sv
rtl/kqt_cell.sv
rtl/keyed_quantity_table.sv
rtl/kqt_checker.sv
sim/tb.sv
